[design/vfts_pkg.sv]
// ----------------------------------------------------------------------------
// vfts_pkg
// Shared types and constants of the vector field trilinear sampler: field
// widths, transfer payloads, operation and register codes.
// ----------------------------------------------------------------------------
package vfts_pkg;

	localparam int COMP_WIDTH  = 16;
	localparam int FRAC_BITS   = 8;
	localparam int POINT_WIDTH = 16;
	localparam int IDX_W       = 12;
	localparam int GRID_W      = 5;
	// Grid coordinates that are ever used lie below the largest grid size.
	localparam int CRD_W       = GRID_W;
	localparam int CFG_IDX_W   = 2;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_Z = 2'd2;

	typedef logic [COMP_WIDTH-1:0] comp_t;
	// Index 0 is x, 1 is y, 2 is z.
	typedef logic [2:0][COMP_WIDTH-1:0] vec_t;
	typedef logic [FRAC_BITS-1:0] frac_t;

	typedef struct packed {
		logic                           opcode;
		logic [IDX_W-1:0]               entry_index;
		logic signed [COMP_WIDTH-1:0]   entry_x;
		logic signed [COMP_WIDTH-1:0]   entry_y;
		logic signed [COMP_WIDTH-1:0]   entry_z;
		logic signed [POINT_WIDTH-1:0]  point_x;
		logic signed [POINT_WIDTH-1:0]  point_y;
		logic signed [POINT_WIDTH-1:0]  point_z;
	} in_item_t;

	typedef struct packed {
		logic signed [COMP_WIDTH-1:0] sample_x;
		logic signed [COMP_WIDTH-1:0] sample_y;
		logic signed [COMP_WIDTH-1:0] sample_z;
		logic                         used_nearest;
		logic                         outside_grid;
	} out_item_t;

	typedef struct packed {
		logic  go;
		vec_t  a;
		vec_t  b;
		frac_t w;
	} lerp_req_t;

endpackage

[design/vfts_ram.sv]
// ----------------------------------------------------------------------------
// vfts_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module vfts_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

[design/vfts_lerp.sv]
// ----------------------------------------------------------------------------
// vfts_lerp
// Shared three-lane lerp unit. A request is registered with its products;
// the rounded result is valid in the following cycle and holds until the
// next request.
// ----------------------------------------------------------------------------
module vfts_lerp
	import vfts_pkg::*;
(
	input  logic      clk,
	input  lerp_req_t req,
	output vec_t      res
);

	localparam int PW = COMP_WIDTH + FRAC_BITS + 2;
	localparam logic signed [PW:0] HALF = (PW+1)'(1) <<< (FRAC_BITS - 1);

	for (genvar l = 0; l < 3; l++) begin : g_lane
		logic signed [COMP_WIDTH:0] diff;
		logic signed [PW-1:0]       prod;
		logic signed [PW-1:0]       prod_s1;
		comp_t                      a_s1;
		logic signed [PW:0]         rnd;

		// a*(1-w) + b*w equals a + (b-a)*w, and a*S is an exact multiple of S.
		always_comb begin
			diff = (COMP_WIDTH+1)'($signed(req.b[l])) - (COMP_WIDTH+1)'($signed(req.a[l]));
			prod = PW'(diff * $signed({1'b0, req.w}));
		end

		always_ff @(posedge clk) begin
			if (req.go) begin
				prod_s1 <= prod;
				a_s1    <= req.a[l];
			end
		end

		always_comb begin
			rnd = ((PW+1)'(prod_s1) + HALF) >>> FRAC_BITS;
			res[l] = a_s1 + rnd[COMP_WIDTH-1:0];
		end
	end

endmodule

[design/vector_field_trilinear_sampler.sv]
// ----------------------------------------------------------------------------
// vector_field_trilinear_sampler
// Trilinear sampling of a stored 3-component vector grid.
// ----------------------------------------------------------------------------
// A load transfer writes one grid entry. A query's result enters the output
// register after the 8 corner reads and the lerps when all 8 corners lie
// inside the grid, after one entry read when the nearest-neighbor fallback
// is used, and with no store read when the point lies outside the grid.
// The interpolation time is set by the single-port field store, which
// gives one corner per cycle, and by the one shared lerp unit, which performs
// the 7 lerps (z, then y, then x) of all three components. No new item is
// taken while a query is being worked on, and a stalled result holds the
// sequencer at its last step. The store has no reset; only entries that were
// loaded may be sampled.
module vector_field_trilinear_sampler
	import vfts_pkg::*;
#(
	parameter int MAX_DIM_X = 16,
	parameter int MAX_DIM_Y = 16,
	parameter int MAX_DIM_Z = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GRID_W-1:0]    cfg_wdata
);

	localparam int DEPTH = MAX_DIM_X * MAX_DIM_Y * MAX_DIM_Z;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = POINT_WIDTH - FRAC_BITS + 2;
	localparam frac_t HALF_FX = frac_t'(1) << (FRAC_BITS - 1);

	localparam logic [3:0] STEP_NEAR    = 4'd1;
	localparam logic [3:0] STEP_LAST_RD = 4'd7;
	localparam logic [3:0] STEP_Y_LO    = 4'd10;
	localparam logic [3:0] STEP_Y_HI    = 4'd11;
	localparam logic [3:0] STEP_Y_HI_WB = 4'd12;
	localparam logic [3:0] STEP_X       = 4'd13;
	localparam logic [3:0] STEP_OUT     = 4'd14;

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	typedef struct packed {
		logic [CRD_W-1:0] lo;
		logic [CRD_W-1:0] hi;
		logic [CRD_W-1:0] nc;
		frac_t            fr;
		logic             tri_ok;
		logic             far;
	} axis_t;

	function automatic axis_t axis_setup(input logic signed [POINT_WIDTH-1:0] p,
	                                     input logic signed [IW-1:0] n);
		axis_t                r;
		logic signed [IW-1:0] lo;
		logic signed [IW-1:0] hi;
		logic signed [IW-1:0] nc;
		frac_t                fr;
		logic                 up;
		lo = IW'(p >>> FRAC_BITS);
		fr = p[FRAC_BITS-1:0];
		hi = lo + IW'(fr != '0);
		// Rounding up needs a fraction above one half and a next index in the grid.
		up = (fr > HALF_FX) && (hi < n);
		nc = up ? hi : lo;
		r.lo     = lo[CRD_W-1:0];
		r.hi     = hi[CRD_W-1:0];
		r.nc     = nc[CRD_W-1:0];
		r.fr     = fr;
		r.tri_ok = !lo[IW-1] && (hi < n);
		r.far    = nc[IW-1] || (nc >= n);
		return r;
	endfunction

	function automatic logic signed [IW-1:0] clamp_size(input logic [GRID_W-1:0] g,
	                                                    input int maxd);
		logic signed [IW-1:0] n;
		if (g == '0) begin
			n = IW'(1);
		end else if (int'(g) > maxd) begin
			n = IW'(maxd);
		end else begin
			n = IW'(g);
		end
		return n;
	endfunction

	state_t              state_q;
	logic [3:0]          cnt_q;
	logic [GRID_W-1:0]   grid_x_q, grid_y_q, grid_z_q;
	logic [CRD_W-1:0]    lo_x_q, lo_y_q, lo_z_q, hi_x_q, hi_y_q, hi_z_q;
	frac_t               fr_x_q, fr_y_q, fr_z_q;
	logic                tri_q, far_q;
	vec_t                even_q;
	vec_t                lr_q [4];
	logic                out_valid_q;
	out_item_t           out_data_q;

	logic signed [IW-1:0] n_x, n_y, n_z;
	axis_t               ax, ay, az;
	logic                in_xfer, is_query, tri_now;
	logic                wr_en, rd_en, is_last, can_out, out_load;
	logic [CRD_W-1:0]    cx, cy, cz;
	logic [AW-1:0]       wr_addr, rd_addr, ram_addr;
	vec_t                ram_wdata, ram_rdata, lerp_res;
	lerp_req_t           req;
	logic [1:0]          lr_wr_idx;
	logic                lr_wr;
	out_item_t           out_next;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_x_q <= GRID_W'(16);
			grid_y_q <= GRID_W'(16);
			grid_z_q <= GRID_W'(16);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_X: grid_x_q <= cfg_wdata;
				REG_GRID_Y: grid_y_q <= cfg_wdata;
				REG_GRID_Z: grid_z_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		n_x = clamp_size(grid_x_q, MAX_DIM_X);
		n_y = clamp_size(grid_y_q, MAX_DIM_Y);
		n_z = clamp_size(grid_z_q, MAX_DIM_Z);
		ax  = axis_setup(in_data.point_x, n_x);
		ay  = axis_setup(in_data.point_y, n_y);
		az  = axis_setup(in_data.point_z, n_z);
		tri_now = ax.tri_ok && ay.tri_ok && az.tri_ok;
	end

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign is_query = (in_data.opcode == OP_QUERY);

	// Store access: loads in idle, corner reads while running.
	always_comb begin
		wr_en     = in_xfer && (in_data.opcode == OP_LOAD)
		            && (32'(in_data.entry_index) < DEPTH);
		wr_addr   = AW'(in_data.entry_index);
		ram_wdata = {in_data.entry_z, in_data.entry_y, in_data.entry_x};
		cx = cnt_q[2] ? hi_x_q : lo_x_q;
		cy = cnt_q[1] ? hi_y_q : lo_y_q;
		cz = cnt_q[0] ? hi_z_q : lo_z_q;
		rd_addr = AW'(32'(cx) + 32'(cy) * MAX_DIM_X + 32'(cz) * (MAX_DIM_X * MAX_DIM_Y));
		rd_en = (state_q == ST_RUN)
		        && (tri_q ? (cnt_q <= STEP_LAST_RD) : (!far_q && cnt_q == '0));
		ram_addr = (state_q == ST_IDLE) ? wr_addr : rd_addr;
	end

	vfts_ram #(
		.WIDTH (3 * COMP_WIDTH),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.en    (wr_en || rd_en),
		.we    (wr_en),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Lerp schedule: z pairs as corners arrive, then y pairs, then x.
	always_comb begin
		req.go = 1'b0;
		req.a  = even_q;
		req.b  = ram_rdata;
		req.w  = fr_z_q;
		if (state_q == ST_RUN && tri_q) begin
			case (cnt_q)
				4'd2, 4'd4, 4'd6, 4'd8: req.go = 1'b1;
				STEP_Y_LO: begin
					req.go = 1'b1;
					req.a  = lr_q[0];
					req.b  = lr_q[1];
					req.w  = fr_y_q;
				end
				STEP_Y_HI: begin
					req.go = 1'b1;
					req.a  = lr_q[2];
					req.b  = lr_q[3];
					req.w  = fr_y_q;
				end
				STEP_X: begin
					req.go = 1'b1;
					req.a  = lr_q[0];
					req.b  = lr_q[1];
					req.w  = fr_x_q;
				end
				default: req.go = 1'b0;
			endcase
		end
	end

	vfts_lerp u_lerp (
		.clk (clk),
		.req (req),
		.res (lerp_res)
	);

	always_comb begin
		lr_wr     = 1'b0;
		lr_wr_idx = cnt_q[2:1] - 2'd1;
		if (state_q == ST_RUN && tri_q) begin
			case (cnt_q)
				4'd3, 4'd5, 4'd7, 4'd9: lr_wr = 1'b1;
				STEP_Y_HI: begin
					lr_wr     = 1'b1;
					lr_wr_idx = 2'd0;
				end
				STEP_Y_HI_WB: begin
					lr_wr     = 1'b1;
					lr_wr_idx = 2'd1;
				end
				default: lr_wr = 1'b0;
			endcase
		end
	end

	always_comb begin
		is_last = tri_q ? (cnt_q == STEP_OUT) : (far_q || cnt_q == STEP_NEAR);
		can_out = !out_valid_q || !out_stall;
		out_load = (state_q == ST_RUN) && is_last && can_out;
		out_next.used_nearest = !tri_q;
		out_next.outside_grid = !tri_q && far_q;
		if (tri_q) begin
			out_next.sample_x = lerp_res[0];
			out_next.sample_y = lerp_res[1];
			out_next.sample_z = lerp_res[2];
		end else if (far_q) begin
			out_next.sample_x = '0;
			out_next.sample_y = '0;
			out_next.sample_z = '0;
		end else begin
			out_next.sample_x = ram_rdata[0];
			out_next.sample_y = ram_rdata[1];
			out_next.sample_z = ram_rdata[2];
		end
	end

	// Query operands and intermediate lerp results.
	always_ff @(posedge clk) begin
		if (in_xfer && is_query) begin
			lo_x_q <= tri_now ? ax.lo : ax.nc;
			lo_y_q <= tri_now ? ay.lo : ay.nc;
			lo_z_q <= tri_now ? az.lo : az.nc;
			hi_x_q <= ax.hi;
			hi_y_q <= ay.hi;
			hi_z_q <= az.hi;
			fr_x_q <= ax.fr;
			fr_y_q <= ay.fr;
			fr_z_q <= az.fr;
		end
		if (state_q == ST_RUN && tri_q && !cnt_q[0] && cnt_q <= STEP_LAST_RD + 4'd1) begin
			// Corners read at odd steps arrive in the next, even step.
		end
		if (state_q == ST_RUN && tri_q && cnt_q[0] && cnt_q <= STEP_LAST_RD) begin
			even_q <= ram_rdata;
		end
		if (lr_wr) begin
			lr_q[lr_wr_idx] <= lerp_res;
		end
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			tri_q       <= 1'b0;
			far_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_data_q  <= out_next;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_xfer && is_query) begin
						state_q <= ST_RUN;
						tri_q   <= tri_now;
						far_q   <= !tri_now && (ax.far || ay.far || az.far);
					end
				end
				ST_RUN: begin
					if (is_last) begin
						if (can_out) begin
							state_q <= ST_IDLE;
							cnt_q   <= '0;
						end
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_query_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && is_query |=> state_q == ST_RUN)
		else $error("query transfer did not start the sequencer");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q == ST_IDLE && !rd_en)
		else $error("store write while a query is running");

	a_result_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_RUN))
		else $error("result appeared without a running query");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> cnt_q <= STEP_OUT && (tri_q || cnt_q <= STEP_NEAR))
		else $error("sequencer step out of range");

endmodule

[dv/vector_field_trilinear_sampler_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector_field_trilinear_sampler_checker
// Watches the load/query channel, the result channel and the register port of
// the sampler. It keeps its own copy of the vector grid and of the grid sizes,
// predicts the sample of every accepted query and compares each result
// transfer, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module vector_field_trilinear_sampler_checker
	import vfts_pkg::*;
#(
	parameter int MAX_DIM_X = 16,
	parameter int MAX_DIM_Y = 16,
	parameter int MAX_DIM_Z = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  in_item_t             in_data,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GRID_W-1:0]    cfg_wdata,
	output int                   errors,
	output int                   pending
);

	localparam int     STORE_DEPTH = MAX_DIM_X * MAX_DIM_Y * MAX_DIM_Z;
	localparam longint ONE         = longint'(1) << FRAC_BITS;

	vec_t              field_mem [STORE_DEPTH];
	logic [GRID_W-1:0] grid_size [3];
	out_item_t         sample_queue [$];

	initial begin
		errors = 0;
		pending = 0;
		grid_size = '{GRID_W'(16), GRID_W'(16), GRID_W'(16)};
	end

	// A size of zero behaves as one, and sizes above the store bound are clipped.
	function automatic longint grid_span(input int axis);
		longint n;
		longint dim_max;
		dim_max = (axis == 0) ? MAX_DIM_X : (axis == 1) ? MAX_DIM_Y : MAX_DIM_Z;
		n = grid_size[axis];
		if (n < 1)
			n = 1;
		if (n > dim_max)
			n = dim_max;
		return n;
	endfunction

	// Exact weighted mean, rounded to nearest with halves rounded up.
	function automatic longint blend(input longint a, input longint b, input longint w);
		return (a * (ONE - w) + b * w + ONE / 2) >>> FRAC_BITS;
	endfunction

	function automatic longint corner(input int comp, input longint x, input longint y,
			input longint z);
		return longint'(signed'(field_mem[x + y * MAX_DIM_X + z * MAX_DIM_X * MAX_DIM_Y][comp]));
	endfunction

	function automatic out_item_t predict_sample(input in_item_t it);
		longint                       p [3];
		longint                       lo [3];
		longint                       hi [3];
		longint                       fr [3];
		longint                       n [3];
		longint                       pick [3];
		longint                       i1, i2, j1, j2, w1, w2;
		logic signed [COMP_WIDTH-1:0] val [3];
		logic                         trilinear;
		logic                         off_grid;
		out_item_t                    res;
		p[0] = longint'(signed'(it.point_x));
		p[1] = longint'(signed'(it.point_y));
		p[2] = longint'(signed'(it.point_z));
		trilinear = 1'b1;
		off_grid = 1'b0;
		for (int a = 0; a < 3; a++) begin
			n[a] = grid_span(a);
			lo[a] = p[a] >>> FRAC_BITS;
			fr[a] = p[a] - lo[a] * ONE;
			hi[a] = (fr[a] != 0) ? lo[a] + 1 : lo[a];
			if (lo[a] < 0 || hi[a] >= n[a])
				trilinear = 1'b0;
		end
		if (trilinear) begin
			// Blend along z first, then y, then x.
			for (int c = 0; c < 3; c++) begin
				i1 = blend(corner(c, lo[0], lo[1], lo[2]), corner(c, lo[0], lo[1], hi[2]), fr[2]);
				i2 = blend(corner(c, lo[0], hi[1], lo[2]), corner(c, lo[0], hi[1], hi[2]), fr[2]);
				j1 = blend(corner(c, hi[0], lo[1], lo[2]), corner(c, hi[0], lo[1], hi[2]), fr[2]);
				j2 = blend(corner(c, hi[0], hi[1], lo[2]), corner(c, hi[0], hi[1], hi[2]), fr[2]);
				w1 = blend(i1, i2, fr[1]);
				w2 = blend(j1, j2, fr[1]);
				val[c] = COMP_WIDTH'(blend(w1, w2, fr[0]));
			end
		end else begin
			// Round up only past one half, and never from the last index onward.
			for (int a = 0; a < 3; a++) begin
				pick[a] = (fr[a] > ONE / 2 && p[a] < (n[a] - 1) * ONE) ? hi[a] : lo[a];
				if (pick[a] < 0 || pick[a] >= n[a])
					off_grid = 1'b1;
			end
			for (int c = 0; c < 3; c++)
				val[c] = off_grid ? '0 : COMP_WIDTH'(corner(c, pick[0], pick[1], pick[2]));
		end
		res.sample_x = val[0];
		res.sample_y = val[1];
		res.sample_z = val[2];
		res.used_nearest = !trilinear;
		res.outside_grid = off_grid;
		return res;
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (sample_queue.size() == 0) begin
					errors++;
					$display("%0t: sample transfer with none expected, got %h", $time, out_data);
				end else begin
					want = sample_queue.pop_front();
					check_field("sample_x", longint'(signed'(want.sample_x)),
						longint'(signed'(out_data.sample_x)));
					check_field("sample_y", longint'(signed'(want.sample_y)),
						longint'(signed'(out_data.sample_y)));
					check_field("sample_z", longint'(signed'(want.sample_z)),
						longint'(signed'(out_data.sample_z)));
					check_field("used_nearest", longint'(want.used_nearest),
						longint'(out_data.used_nearest));
					check_field("outside_grid", longint'(want.outside_grid),
						longint'(out_data.outside_grid));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_GRID_X: grid_size[0] = cfg_wdata;
					REG_GRID_Y: grid_size[1] = cfg_wdata;
					REG_GRID_Z: grid_size[2] = cfg_wdata;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (in_data.opcode == OP_QUERY)
					sample_queue.push_back(predict_sample(in_data));
				else if (in_data.entry_index < STORE_DEPTH)
					field_mem[in_data.entry_index] = {in_data.entry_z, in_data.entry_y, in_data.entry_x};
			end
			pending = sample_queue.size();
		end
	end

endmodule

[dv/vector_field_trilinear_sampler_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector_field_trilinear_sampler_test
// Drives grid loads, queries and grid size writes into the sampler. A short
// directed part covers extreme components, rounding at one half, the last
// index and points off the grid; random phases follow with several grid
// sizes and with idling on both channels. Before every query the entries it
// may read are loaded, so no unwritten entry is ever sampled.
// ----------------------------------------------------------------------------
module vector_field_trilinear_sampler_test;
	import vfts_pkg::*;

	localparam int MAX_DIM_X     = 16;
	localparam int MAX_DIM_Y     = 16;
	localparam int MAX_DIM_Z     = 16;
	localparam int STORE_DEPTH   = MAX_DIM_X * MAX_DIM_Y * MAX_DIM_Z;
	localparam int SETTLE_CYCLES = 24;
	localparam int FRAC_MASK     = (1 << FRAC_BITS) - 1;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [GRID_W-1:0]    cfg_wdata;
	int                   errors;
	int                   pending;

	int idle_pct = 0;
	int stall_pct = 0;
	int sent = 0;
	int dim_max [3] = '{MAX_DIM_X, MAX_DIM_Y, MAX_DIM_Z};
	int grid_span [3] = '{16, 16, 16};
	bit written [STORE_DEPTH];

	vector_field_trilinear_sampler #(
		.MAX_DIM_X(MAX_DIM_X),
		.MAX_DIM_Y(MAX_DIM_Y),
		.MAX_DIM_Z(MAX_DIM_Z)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	vector_field_trilinear_sampler_checker #(
		.MAX_DIM_X(MAX_DIM_X),
		.MAX_DIM_Y(MAX_DIM_Y),
		.MAX_DIM_Z(MAX_DIM_Z)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.errors(errors),
		.pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	initial begin
		#5_000_000;
		$display("[vector_field_trilinear_sampler] ERROR");
		$finish;
	end

	function automatic in_item_t noise_item();
		in_item_t it;
		it.opcode = $urandom;
		it.entry_index = $urandom;
		it.entry_x = $urandom;
		it.entry_y = $urandom;
		it.entry_z = $urandom;
		it.point_x = $urandom;
		it.point_y = $urandom;
		it.point_z = $urandom;
		return it;
	endfunction

	// Valid stays high after a transfer until the next call decides whether
	// a gap comes first, so it is never lowered and raised in one step.
	task automatic send(input in_item_t it);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < idle_pct)
			gap++;
		@(negedge clk);
		while (gap > 0) begin
			in_valid <= 1'b0;
			in_data <= noise_item();
			gap--;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		sent++;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain(input int settle);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_grid(input int sx, input int sy, input int sz);
		logic [CFG_IDX_W-1:0] code [3];
		int                   val [3];
		code = '{REG_GRID_X, REG_GRID_Y, REG_GRID_Z};
		val = '{sx, sy, sz};
		drain(SETTLE_CYCLES);
		for (int r = 0; r < 3; r++) begin
			cfg_we <= 1'b1;
			cfg_index <= code[r];
			cfg_wdata <= GRID_W'(val[r]);
			grid_span[r] = (val[r] < 1) ? 1 : (val[r] > dim_max[r]) ? dim_max[r] : val[r];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic load_entry(input int idx, input logic [COMP_WIDTH-1:0] ex,
			input logic [COMP_WIDTH-1:0] ey, input logic [COMP_WIDTH-1:0] ez);
		in_item_t it;
		it = noise_item();
		it.opcode = OP_LOAD;
		it.entry_index = IDX_W'(idx);
		it.entry_x = ex;
		it.entry_y = ey;
		it.entry_z = ez;
		written[idx] = 1'b1;
		send(it);
	endtask

	// Every in-grid combination of the lower and upper neighbor per axis covers
	// both the trilinear corners and the nearest-neighbor pick.
	task automatic load_corners(input in_item_t q);
		logic signed [POINT_WIDTH-1:0] pt [3];
		int                            lo [3];
		int                            hi [3];
		int                            crd [3];
		int                            idx;
		bit                            in_grid;
		pt = '{q.point_x, q.point_y, q.point_z};
		for (int a = 0; a < 3; a++) begin
			lo[a] = int'(pt[a]) >>> FRAC_BITS;
			hi[a] = (pt[a][FRAC_BITS-1:0] != 0) ? lo[a] + 1 : lo[a];
		end
		for (int b = 0; b < 8; b++) begin
			in_grid = 1'b1;
			for (int a = 0; a < 3; a++) begin
				crd[a] = b[a] ? hi[a] : lo[a];
				if (crd[a] < 0 || crd[a] >= grid_span[a])
					in_grid = 1'b0;
			end
			if (in_grid) begin
				idx = crd[0] + crd[1] * MAX_DIM_X + crd[2] * MAX_DIM_X * MAX_DIM_Y;
				if (!written[idx])
					load_entry(idx, COMP_WIDTH'($urandom), COMP_WIDTH'($urandom),
						COMP_WIDTH'($urandom));
			end
		end
	endtask

	task automatic query(input int px, input int py, input int pz);
		in_item_t q;
		q = noise_item();
		q.opcode = OP_QUERY;
		q.point_x = POINT_WIDTH'(px);
		q.point_y = POINT_WIDTH'(py);
		q.point_z = POINT_WIDTH'(pz);
		load_corners(q);
		send(q);
	endtask

	// Mostly points near the used grid, with integer and half fractions
	// favored; the rest spans the whole coordinate range.
	function automatic int pick_coord(input int n);
		int v;
		int r;
		r = $urandom_range(99);
		if (r < 20)
			return int'($urandom_range(65535)) - 32768;
		v = int'($urandom_range((n + 1) << FRAC_BITS)) - 160;
		r = $urandom_range(99);
		if (r < 15)
			v = v & ~FRAC_MASK;
		else if (r < 25)
			v = (v & ~FRAC_MASK) | (1 << (FRAC_BITS - 1));
		return v;
	endfunction

	initial begin
		int sizes_x [7];
		int sizes_y [7];
		int sizes_z [7];
		int target;
		sizes_x = '{16, 1, 0, 5, 16, 1, 2};
		sizes_y = '{16, 1, 31, 3, 1, 16, 2};
		sizes_z = '{16, 1, 2, 7, 1, 2, 16};
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = REG_GRID_X;
		cfg_wdata = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part on a 3 x 2 x 2 grid filled with extreme components.
		write_grid(3, 2, 2);
		for (int i = 0; i < 12; i++) begin
			if (i % 2 == 0)
				load_entry(i % 3 + ((i / 3) % 2) * MAX_DIM_X + (i / 6) * MAX_DIM_X * MAX_DIM_Y,
					16'h7fff, 16'h8000, 16'h0001);
			else
				load_entry(i % 3 + ((i / 3) % 2) * MAX_DIM_X + (i / 6) * MAX_DIM_X * MAX_DIM_Y,
					16'h8000, 16'h7fff, 16'hffff);
		end
		query(0, 0, 0);
		query('h80, 'h80, 'h80);
		query('h1ff, 'hff, 'h01);
		query('h200, 'h100, 'h100);
		query('h201, 0, 0);
		query('h290, 0, 0);
		query('h181, 'h110, 0);
		query('h180, 'h110, 0);
		query(-'h10, 0, 0);
		query(-'h90, 0, 0);
		query(32767, 32767, 32767);
		query(-32768, -32768, -32768);
		query(0, 'h300, 0);
		query(0, 0, 'h180);

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct <= 0; end
				1: begin idle_pct = 49; stall_pct <= 0; end
				2: begin idle_pct = 0; stall_pct <= 49; end
				default: begin idle_pct = 24; stall_pct <= 24; end
			endcase
			if (ph < 7)
				write_grid(sizes_x[ph], sizes_y[ph], sizes_z[ph]);
			else
				write_grid($urandom_range(31), $urandom_range(31), $urandom_range(31));
			target = sent + 56;
			while (sent < target) begin
				if ($urandom_range(99) < 2)
					drain(0);
				if ($urandom_range(99) < 15)
					load_entry($urandom_range(STORE_DEPTH - 1), COMP_WIDTH'($urandom),
						COMP_WIDTH'($urandom), COMP_WIDTH'($urandom));
				else
					query(pick_coord(grid_span[0]), pick_coord(grid_span[1]),
						pick_coord(grid_span[2]));
			end
		end

		drain(SETTLE_CYCLES);
		if (errors == 0)
			$display("[vector_field_trilinear_sampler] OK");
		else
			$display("[vector_field_trilinear_sampler] ERROR");
		$finish;
	end

endmodule
